FILE: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rmst_pkg.sv
// types and constants of the range minimum segment tree
`timescale 1ns / 1ps

package rmst_pkg;

    localparam int LEAVES     = 1024;
    localparam int LEAF_BITS  = $clog2(LEAVES);
    localparam int NODE_BITS  = LEAF_BITS + 1;
    localparam int NODE_COUNT = 2 * LEAVES;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 11;

    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    localparam logic FUNC_SET   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic REG_LEAF_COUNT = 1'b0;

    localparam logic [COUNT_BITS-1:0] LEAF_COUNT_RESET = COUNT_BITS'(LEAVES);

    typedef struct packed {
        logic                         func;
        logic [LEAF_BITS-1:0]         position;
        logic signed [VALUE_BITS-1:0] new_value;
        logic [LEAF_BITS-1:0]         left_index;
        logic [LEAF_BITS-1:0]         right_index;
    } t_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] min_value;
        logic                         range_empty;
    } t_result;

    typedef struct packed {
        logic idle;
        logic clearing;
    } t_eng_status;

endpackage

FILE: design/rmst_engine.sv
// node memory with the update and query sequencer
`timescale 1ns / 1ps

module rmst_engine
    import rmst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_item                 i_item,
    input  logic [COUNT_BITS-1:0] i_leaf_count,
    input  logic                  i_res_taken,
    output t_eng_status           o_status,
    output logic                  o_res_valid,
    output t_result               o_result
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LEAF   = 3'd2;
    localparam logic [2:0] ST_UP     = 3'd3;
    localparam logic [2:0] ST_QLEFT  = 3'd4;
    localparam logic [2:0] ST_QRIGHT = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    localparam logic [NODE_BITS-1:0] ROOT = NODE_BITS'(1);

    logic signed [VALUE_BITS-1:0] r_mem [NODE_COUNT];
    logic signed [VALUE_BITS-1:0] r_rd_data;

    logic [2:0]                   r_state, n_state;
    logic [NODE_BITS-1:0]         r_clr_addr, n_clr_addr;
    logic [NODE_BITS-1:0]         r_k, n_k;
    logic signed [VALUE_BITS-1:0] r_cur, n_cur;
    logic [NODE_BITS:0]           r_a, n_a;
    logic [NODE_BITS:0]           r_b, n_b;
    logic signed [VALUE_BITS-1:0] r_best, n_best;
    logic                         r_pend, n_pend;
    logic                         r_empty, n_empty;

    logic                         w_wr_en;
    logic [NODE_BITS-1:0]         w_wr_addr;
    logic signed [VALUE_BITS-1:0] w_wr_data;
    logic                         w_rd_en;
    logic [NODE_BITS-1:0]         w_rd_addr;

    logic [COUNT_BITS-1:0]        w_active;
    logic [COUNT_BITS-1:0]        w_last;
    logic [COUNT_BITS-1:0]        w_hi;
    logic                         w_q_empty;
    logic signed [VALUE_BITS-1:0] w_up_min;
    logic [NODE_BITS-1:0]         w_parent;
    logic [NODE_BITS:0]           w_a_inc;
    logic [NODE_BITS:0]           w_b_dec;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // clip the query range to the active leaves
    always_comb begin
        w_active  = (i_leaf_count > COUNT_BITS'(LEAVES)) ? COUNT_BITS'(LEAVES) : i_leaf_count;
        w_last    = w_active - COUNT_BITS'(1);
        w_hi      = ({1'b0, i_item.right_index} > w_last) ? w_last
                                                          : {1'b0, i_item.right_index};
        w_q_empty = (w_active == '0) || ({1'b0, i_item.left_index} > w_hi);
    end

    assign w_up_min = (r_rd_data < r_cur) ? r_rd_data : r_cur;
    assign w_parent = r_k >> 1;
    assign w_a_inc  = r_a + (NODE_BITS+1)'(1);
    assign w_b_dec  = r_b - (NODE_BITS+1)'(1);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_k        = r_k;
        n_cur      = r_cur;
        n_a        = r_a;
        n_b        = r_b;
        n_empty    = r_empty;
        n_pend     = 1'b0;
        n_best     = (r_pend && (r_rd_data < r_best)) ? r_rd_data : r_best;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_k;
        w_wr_data  = r_cur;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_k ^ ROOT;
        case (r_state)
            ST_CLEAR: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_addr;
                w_wr_data  = VAL_MAX;
                n_clr_addr = r_clr_addr + NODE_BITS'(1);
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    if (i_item.func == FUNC_SET) begin
                        n_k     = {1'b1, i_item.position};
                        n_cur   = i_item.new_value;
                        n_state = ST_LEAF;
                    end else begin
                        n_a     = {2'b01, i_item.left_index};
                        n_b     = {2'b01, w_hi[LEAF_BITS-1:0]} + (NODE_BITS+1)'(1);
                        n_best  = VAL_MAX;
                        n_empty = w_q_empty;
                        n_state = w_q_empty ? ST_DONE : ST_QLEFT;
                    end
                end
            end
            ST_LEAF: begin
                w_wr_en = 1'b1;
                w_rd_en = 1'b1;
                n_state = ST_UP;
            end
            ST_UP: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_parent;
                w_wr_data = w_up_min;
                n_cur     = w_up_min;
                n_k       = w_parent;
                if (w_parent == ROOT) begin
                    n_state = ST_IDLE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_parent ^ ROOT;
                end
            end
            ST_QLEFT: begin
                if (r_a < r_b) begin
                    if (r_a[0]) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_a[NODE_BITS-1:0];
                        n_pend    = 1'b1;
                        n_a       = w_a_inc;
                    end
                    n_state = ST_QRIGHT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_QRIGHT: begin
                if (r_b[0]) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_b_dec[NODE_BITS-1:0];
                    n_pend    = 1'b1;
                end
                n_a     = r_a >> 1;
                n_b     = r_b >> 1;
                n_state = ST_QLEFT;
            end
            ST_DONE: begin
                if (i_res_taken) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_pend     <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_cur   <= n_cur;
        r_a     <= n_a;
        r_b     <= n_b;
        r_best  <= n_best;
        r_empty <= n_empty;
    end

    assign o_status.idle      = (r_state == ST_IDLE);
    assign o_status.clearing  = (r_state == ST_CLEAR);
    assign o_res_valid        = (r_state == ST_DONE);
    assign o_result.min_value   = r_best;
    assign o_result.range_empty = r_empty;

endmodule

FILE: design/range_minimum_segment_tree.sv
// top level: stream ports, leaf count register and result register
//
// channel   direction  accepted when                      payload
// request   in         i_s_axis_tvalid & o_s_axis_tready  tdata, tuser (func)
// result    out        o_m_axis_tvalid & i_m_axis_tready  tdata (min), tuser (empty)
// config    in         psel & penable & pwrite            pwdata -> leaf_count
//
// a set request writes the leaf, then per level reads the sibling and writes the parent
// a query walks up the tree levels, reading at most one node per side on each level
// through the single read port; an empty query goes straight to the result
// after reset all 2048 nodes of the memory are swept to the maximum value, with no requests taken
// one request is in flight at a time; a query result waiting in the output register
// does not hold off the next request, only the delivery of the next result
`timescale 1ns / 1ps
`include "assert_macros.svh"

module range_minimum_segment_tree
    import rmst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // position[9:0], new_value[41:10], left_index[51:42], right_index[61:52], zeros
    input  logic [63:0] i_s_axis_tdata,
    // func[0]
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // min_value[31:0]
    output logic [31:0] o_m_axis_tdata,
    // range_empty[0]
    output logic [0:0]  o_m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_item                 w_item;
    t_eng_status           w_status;
    t_result               w_result;
    logic                  w_res_valid;
    logic                  w_res_taken;
    logic                  w_accept;
    logic                  w_cfg_wr;

    logic [COUNT_BITS-1:0] r_leaf_count;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out;

    assign w_item.func        = i_s_axis_tuser[0];
    assign w_item.position    = i_s_axis_tdata[9:0];
    assign w_item.new_value   = i_s_axis_tdata[41:10];
    assign w_item.left_index  = i_s_axis_tdata[51:42];
    assign w_item.right_index = i_s_axis_tdata[61:52];

    assign o_s_axis_tready = w_status.idle;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_res_taken     = !r_out_valid || i_m_axis_tready;

    rmst_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_accept),
        .i_item       (w_item),
        .i_leaf_count (r_leaf_count),
        .i_res_taken  (w_res_taken),
        .o_status     (w_status),
        .o_res_valid  (w_res_valid),
        .o_result     (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_valid && w_res_taken) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_taken) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out.min_value;
    assign o_m_axis_tuser[0] = r_out.range_empty;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LEAF_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= LEAF_COUNT_RESET;
        end else if (w_cfg_wr) begin
            r_leaf_count <= pwdata[COUNT_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LEAF_COUNT) ? {(32-COUNT_BITS)'(0), r_leaf_count} : '0;

    `ASSERT_IMPLIES(a_no_req_clear, i_clk, i_rst_n, w_status.clearing, !o_s_axis_tready, "request taken during memory sweep")
    `ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, w_accept, !o_s_axis_tready, "second request taken while one is in flight")
    `ASSERT_IMPLIES(a_empty_max, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == VAL_MAX, "empty result without maximum value")

endmodule

FILE: tb/sv/range_minimum_segment_tree_tb.sv
// testbench of the range minimum segment tree: set and query requests checked against a predictor
`timescale 1ns / 1ps

module range_minimum_segment_tree_tb;
    import rmst_pkg::*;

    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 11;
    localparam int PHASE_ITEMS   = 41;

    class min_tree_tracker;
        logic signed [VALUE_BITS-1:0] leaf_vals[LEAVES];
        logic [COUNT_BITS-1:0]        leaf_count;
        t_result                      pending_minima[$];
        int                           faults;

        function new();
            foreach (leaf_vals[k]) leaf_vals[k] = VAL_MAX;
            leaf_count = LEAF_COUNT_RESET;
            faults = 0;
        endfunction

        function void take_request(t_item req);
            int active;
            int hi;
            logic signed [VALUE_BITS-1:0] best;
            t_result ans;
            if (req.func == FUNC_SET) begin
                leaf_vals[req.position] = req.new_value;
                return;
            end
            active = (leaf_count > LEAVES) ? LEAVES : int'(leaf_count);
            hi = (int'(req.right_index) > active - 1) ? active - 1 : int'(req.right_index);
            best = VAL_MAX;
            ans.range_empty = (active == 0) || (int'(req.left_index) > hi);
            if (!ans.range_empty) begin
                for (int k = int'(req.left_index); k <= hi; k++) begin
                    if (leaf_vals[k] < best) best = leaf_vals[k];
                end
            end
            ans.min_value = best;
            pending_minima.push_back(ans);
        endfunction

        function void compare_answer(logic [31:0] data, logic empty_flag);
            t_result want;
            if (pending_minima.size() == 0) begin
                $error("result with no query waiting: min_value %0d range_empty %0d",
                       $signed(data), empty_flag);
                faults++;
                return;
            end
            want = pending_minima.pop_front();
            if (data !== want.min_value) begin
                $error("min_value expected %0d actual %0d", $signed(want.min_value),
                       $signed(data));
                faults++;
            end
            if (empty_flag !== want.range_empty) begin
                $error("range_empty expected %0d actual %0d", want.range_empty, empty_flag);
                faults++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // position[9:0], new_value[41:10], left_index[51:42], right_index[61:52], zeros
    logic [63:0] i_s_axis_tdata = '0;
    // func[0]
    logic [0:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // min_value[31:0]
    logic [31:0] o_m_axis_tdata;
    // range_empty[0]
    logic [0:0]  o_m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    min_tree_tracker tracker = new();
    bit              calm = 1'b0;
    int              idle_cycles = 0;

    range_minimum_segment_tree u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic send_request(input t_item req);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, req.right_index, req.left_index, req.new_value, req.position};
        i_s_axis_tuser  <= req.func;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        tracker.take_request(req);
        @(negedge i_clk);
    endtask

    task automatic send_set(input logic [LEAF_BITS-1:0] pos,
                            input logic signed [VALUE_BITS-1:0] val);
        t_item req;
        req = '{func: FUNC_SET, position: pos, new_value: val,
                left_index: LEAF_BITS'($urandom), right_index: LEAF_BITS'($urandom)};
        send_request(req);
    endtask

    task automatic send_query(input logic [LEAF_BITS-1:0] lo, input logic [LEAF_BITS-1:0] hi);
        t_item req;
        req = '{func: FUNC_QUERY, position: LEAF_BITS'($urandom), new_value: $urandom,
                left_index: lo, right_index: hi};
        send_request(req);
    endtask

    task automatic random_request(input int lc);
        int span;
        int pick;
        int lo;
        int hi;
        logic signed [VALUE_BITS-1:0] val;
        t_item req;
        span = (lc > LEAVES) ? LEAVES : ((lc == 0) ? 16 : lc);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            req = '{func: 1'($urandom), position: LEAF_BITS'($urandom), new_value: $urandom,
                    left_index: LEAF_BITS'($urandom), right_index: LEAF_BITS'($urandom)};
            send_request(req);
        end else if (pick < 58) begin
            case ($urandom_range(0, 7))
                0: val = ~VAL_MAX;
                1: val = VAL_MAX;
                2, 3, 4: val = int'($urandom_range(0, 400)) - 200;
                default: val = $urandom;
            endcase
            if ($urandom_range(0, 7) == 0) send_set(LEAF_BITS'($urandom), val);
            else send_set(LEAF_BITS'($urandom_range(0, span - 1)), val);
        end else begin
            if ($urandom_range(0, 6) == 0) begin
                lo = $urandom_range(0, LEAVES - 1);
                hi = $urandom_range(0, LEAVES - 1);
            end else begin
                lo = $urandom_range(0, span - 1);
                hi = $urandom_range(lo, span - 1);
            end
            send_query(LEAF_BITS'(lo), LEAF_BITS'(hi));
        end
    endtask

    task automatic write_leaf_count(input logic [COUNT_BITS-1:0] cnt);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(REG_LEAF_COUNT));
        pwdata  <= 32'(cnt);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.leaf_count = cnt;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (tracker.pending_minima.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // result side: ready in random stretches, with random stalls between them
    initial begin
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.compare_answer(o_m_axis_tdata, o_m_axis_tuser[0]);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (psel && penable && pwrite)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("range_minimum_segment_tree_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int lc_plan[PHASES];
        lc_plan = '{1024, 1, 0, 2047, 2, 0, 0, 0, 1023, 0, 1024};
        lc_plan[5] = $urandom_range(3, 64);
        lc_plan[6] = $urandom_range(3, 64);
        lc_plan[7] = $urandom_range(65, 1024);
        lc_plan[9] = $urandom_range(3, 64);
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            calm = (ph == PHASES - 1);
            write_leaf_count(COUNT_BITS'(lc_plan[ph]));
            if (ph == 0) begin
                send_query(0, 1023);
                send_set(0, ~VAL_MAX);
                send_set(1023, VAL_MAX);
                send_set(512, -1);
                send_set(5, 7);
                send_query(0, 1023);
                send_query(1, 1023);
                send_query(1023, 1023);
                send_query(5, 5);
                send_query(513, 1022);
                // inverted range
                send_query(700, 3);
                send_set(0, 100);
                send_query(0, 4);
                send_query(0, 0);
                send_set(1023, ~VAL_MAX);
                send_query(600, 1023);
            end
            repeat (PHASE_ITEMS) random_request(lc_plan[ph]);
            i_s_axis_tvalid <= 1'b0;
        end
        drain();
        if (tracker.faults == 0) begin
            $display("range_minimum_segment_tree_tb: clean");
        end else begin
            $display("range_minimum_segment_tree_tb: errors");
        end
        $finish;
    end

endmodule
